>>> hw/rtl/gbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] BLANK_GLYPH = 8'hff;

  // register indexes, word addressed
  localparam logic [2:0] REG_GLYPH_ADVANCE = 3'd0;
  localparam logic [2:0] REG_SPACE_ADVANCE = 3'd1;
  localparam logic [2:0] REG_BASE_CODE     = 3'd2;
  localparam logic [2:0] REG_GLYPH_COUNT   = 3'd3;
  localparam logic [2:0] REG_TABLE_LENGTH  = 3'd4;
  localparam logic [2:0] REG_ENTRY_BUDGET  = 3'd5;

  localparam logic [7:0] GLYPH_ADVANCE_RST = 8'd8;
  localparam logic [7:0] SPACE_ADVANCE_RST = 8'd0;
  localparam logic [7:0] BASE_CODE_RST     = 8'd32;
  localparam logic [7:0] GLYPH_COUNT_RST   = 8'd64;
  localparam logic [7:0] TABLE_LENGTH_RST  = 8'd0;
  localparam logic [7:0] ENTRY_BUDGET_RST  = 8'd32;

  typedef enum logic {
    OP_TABLE_WRITE = 1'b0,
    OP_CHAR        = 1'b1
  } op_e;

  typedef enum logic {
    KIND_ENTRY = 1'b0,
    KIND_END   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] table_slot;
    logic [7:0] table_glyph;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] glyph_number;
    logic [7:0] pen_x;
    logic [7:0] entry_count;
    status_e    status;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/glyph_run_builder.sv
`timescale 1ns / 1ps
`default_nettype none

// Glyph run builder: turns a text line into glyph placements.
// Input channel (in_valid_i / in_stall_o / in_item_i): op OP_TABLE_WRITE loads
// one slot of the character-to-glyph table, op OP_CHAR processes one
// character. NUL or newline closes the run with a summary item (last = 1).
// Output channel (out_valid_o / out_stall_i / out_item_o) carries zero or one
// item per accepted input item, in order.
// Configuration sits on an APB-style port, one 8-bit register per word;
// write it only while the block is idle. pready is tied high.
// A result is registered in two steps: the table is read as the item is
// accepted, then the compute stage writes the output register.
// Throughput: one item per cycle unless the receiver stalls; the pen / entry
// count update (compute stage) and the single table RAM port serve one item each.
// Reset clears the pen, count and budget-full flag and loads the register
// defaults; table contents are undefined until written.
// While the receiver stalls, the output item holds and the compute stage
// holds; the input stalls once the compute stage is occupied and cannot move.
module glyph_run_builder #(
  parameter int unsigned TABLE_DEPTH = gbr_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire gbr_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output gbr_pkg::out_item_t     out_item_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  import gbr_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // configuration registers
  logic [7:0] glyph_advance_q, space_advance_q, base_code_q;
  logic [7:0] glyph_count_q, table_length_q, entry_budget_q;
  logic       cfg_we;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_advance_q <= GLYPH_ADVANCE_RST;
      space_advance_q <= SPACE_ADVANCE_RST;
      base_code_q     <= BASE_CODE_RST;
      glyph_count_q   <= GLYPH_COUNT_RST;
      table_length_q  <= TABLE_LENGTH_RST;
      entry_budget_q  <= ENTRY_BUDGET_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_GLYPH_ADVANCE: glyph_advance_q <= pwdata[7:0];
        REG_SPACE_ADVANCE: space_advance_q <= pwdata[7:0];
        REG_BASE_CODE:     base_code_q     <= pwdata[7:0];
        REG_GLYPH_COUNT:   glyph_count_q   <= pwdata[7:0];
        REG_TABLE_LENGTH:  table_length_q  <= pwdata[7:0];
        REG_ENTRY_BUDGET:  entry_budget_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_GLYPH_ADVANCE: prdata[7:0] = glyph_advance_q;
      REG_SPACE_ADVANCE: prdata[7:0] = space_advance_q;
      REG_BASE_CODE:     prdata[7:0] = base_code_q;
      REG_GLYPH_COUNT:   prdata[7:0] = glyph_count_q;
      REG_TABLE_LENGTH:  prdata[7:0] = table_length_q;
      REG_ENTRY_BUDGET:  prdata[7:0] = entry_budget_q;
      default:           prdata      = '0;
    endcase
  end

  // input stage and table access
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      s1_go;
  logic      in_accept;
  logic      ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  assign s1_go      = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  // drop table writes beyond the table depth
  assign ram_we   = (in_item_i.op == OP_TABLE_WRITE) &&
                    ({1'b0, in_item_i.table_slot} < 9'(TABLE_DEPTH));
  assign ram_addr = (in_item_i.op == OP_CHAR) ? in_item_i.char_code[AW-1:0]
                                              : in_item_i.table_slot[AW-1:0];

  gbr_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (in_accept),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_item_i.table_glyph),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
  end

  // compute stage
  logic [7:0] pen_q, pen_d;
  logic [7:0] count_q, count_d;
  logic       ovf_q, ovf_d;
  logic       invalid, in_table, is_end;
  logic [7:0] ch, glyph, space_adv;
  logic       res_valid;
  out_item_t  res;
  logic       out_valid_q;
  out_item_t  out_item_q;

  assign ch        = s1_item_q.char_code;
  assign invalid   = (glyph_count_q == 8'd0) || (glyph_advance_q == 8'd0);
  assign is_end    = (ch == CH_NUL) || (ch == CH_NEWLINE);
  assign in_table  = (ch < table_length_q) && ({1'b0, ch} < 9'(TABLE_DEPTH));
  assign space_adv = (space_advance_q != 8'd0) ? space_advance_q : glyph_advance_q;

  always_comb begin
    if (in_table) begin
      glyph = ram_rdata;
    end else if (ch >= base_code_q) begin
      glyph = ch - base_code_q;
    end else begin
      glyph = BLANK_GLYPH;
    end
  end

  always_comb begin
    pen_d     = pen_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    res_valid = 1'b0;
    res       = '{kind: KIND_ENTRY, status: STATUS_OK, default: '0};
    if (s1_go && s1_item_q.op == OP_CHAR) begin
      if (is_end) begin
        res_valid       = 1'b1;
        res.kind        = KIND_END;
        res.entry_count = count_q;
        res.last        = 1'b1;
        res.status      = invalid ? STATUS_INVALID : (ovf_q ? STATUS_FULL : STATUS_OK);
        pen_d           = '0;
        count_d         = '0;
        ovf_d           = 1'b0;
      end else if (!invalid && !ovf_q) begin
        if (ch == CH_SPACE) begin
          pen_d = pen_q + space_adv;
        end else if (glyph < glyph_count_q) begin
          if (count_q >= entry_budget_q) begin
            // latch budget full; ignore the rest of the run
            ovf_d = 1'b1;
          end else begin
            res_valid        = 1'b1;
            res.glyph_number = glyph;
            res.pen_x        = pen_q;
            count_d          = count_q + 8'd1;
            pen_d            = pen_q + glyph_advance_q;
          end
        end else begin
          pen_d = pen_q + glyph_advance_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pen_q   <= pen_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // end of run clears the run state
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_item_q.op == OP_CHAR && is_end
    |=> pen_q == 8'd0 && count_q == 8'd0 && !ovf_q)
    else $error("run state not cleared after end of run");

  // compute stage holds its item while blocked
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_item_q))
    else $error("compute stage item lost while blocked");

  // placed glyph lies below the glyph count
  a_glyph_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.kind == KIND_ENTRY
    |-> out_item_q.glyph_number < glyph_count_q && !out_item_q.last)
    else $error("glyph entry out of range");

endmodule

`default_nettype wire

>>> hw/rtl/gbr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire
